>>> sv/coordinate_moving_average_core_macros.svh
// assertion macros used by the checker file
// both sample on i_clk and are disabled while i_rst_n is low
`ifndef COORDINATE_MOVING_AVERAGE_CORE_MACROS_SVH
`define COORDINATE_MOVING_AVERAGE_CORE_MACROS_SVH

// same-cycle implication
`define CMA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("coordinate moving average assertion failed");

// next-cycle implication
`define CMA_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("coordinate moving average assertion failed");

`endif

>>> sv/cma_pkg.sv
package cma_pkg;

    localparam int TAG_W             = 8;
    localparam int COORD_W           = 16;
    localparam int DEF_WINDOW_LENGTH = 20;

    localparam logic [TAG_W-1:0]   ACCEPT_TAG = 8'h07;
    localparam logic [COORD_W-1:0] CENTRE_X   = 16'd320;
    localparam logic [COORD_W-1:0] CENTRE_Y   = 16'd240;

    typedef enum logic [1:0] {
        STATUS_IGNORED  = 2'd0,
        STATUS_CENTRED  = 2'd1,
        STATUS_FILTERED = 2'd2
    } t_status;

endpackage

>>> sv/cma_window.sv
module cma_window
    import cma_pkg::*;
#(
    parameter int                 DEPTH       = DEF_WINDOW_LENGTH,
    parameter logic [COORD_W-1:0] RESET_VALUE = CENTRE_X
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]   i_wr_addr,
    input  logic [COORD_W-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0]   i_rd_addr,
    output logic [COORD_W-1:0]         o_rd_data
);

    logic [COORD_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]   r_vld;
    logic [COORD_W-1:0] r_rd_data;
    logic               r_rd_vld;

    // entry valid bits, an unwritten entry reads as the reset value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            r_rd_vld <= r_vld[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : RESET_VALUE;

endmodule

>>> sv/cma_div.sv
module cma_div
    import cma_pkg::*;
#(
    parameter int WINDOW_LENGTH = DEF_WINDOW_LENGTH
) (
    input  logic                                        i_clk,
    input  logic                                        i_en,
    input  logic [COORD_W+$clog2(WINDOW_LENGTH)-1:0]   i_sum,
    output logic [COORD_W-1:0]                          o_quot
);

    localparam int POS_W  = $clog2(WINDOW_LENGTH);
    localparam int SUM_W  = COORD_W + POS_W;
    localparam int SHIFT  = SUM_W + POS_W;
    localparam int MUL_W  = SUM_W + 1;
    localparam int PROD_W = SUM_W + MUL_W;
    // ceil(2^SHIFT / length) gives an exact floor quotient for every sum
    localparam logic [63:0] RECIP_WIDE =
        ((64'd1 << SHIFT) + 64'(WINDOW_LENGTH) - 64'd1) / 64'(WINDOW_LENGTH);
    localparam logic [MUL_W-1:0] RECIP = RECIP_WIDE[MUL_W-1:0];

    logic [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= PROD_W'(i_sum) * PROD_W'(RECIP);
        end
    end

    assign o_quot = r_prod[SHIFT +: COORD_W];

endmodule

>>> sv/coordinate_moving_average_core.sv
// a result shows on o_m_axis_tvalid once it has passed stages a, b, c and d
// throughput: one transaction per cycle while the output is not stalled; the running-sum
// update is combinational and the divide by the window length is a registered reciprocal multiply
// reset: synchronous active-low i_rst_n empties the pipeline, sets the sums to
// length times the centre, the aim to the centre and the write position to 0
module coordinate_moving_average_core
    import cma_pkg::*;
#(
    parameter int WINDOW_LENGTH = DEF_WINDOW_LENGTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input report stream
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [31:0]          i_s_axis_tdata,   // raw_x [15:0], raw_y [31:16]
    input  logic [TAG_W-1:0]     i_s_axis_tuser,   // packet_tag [7:0]
    // aim result stream
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [31:0]          o_m_axis_tdata,   // aim_x [15:0], aim_y [31:16]
    output logic [1:0]           o_m_axis_tuser    // aim_status [1:0]
);

    localparam int POS_W = $clog2(WINDOW_LENGTH);
    localparam int SUM_W = COORD_W + POS_W;
    localparam logic [POS_W-1:0] POS_LAST  = POS_W'(WINDOW_LENGTH - 1);
    localparam logic [SUM_W-1:0] X_SUM_RST = SUM_W'(WINDOW_LENGTH * int'(CENTRE_X));
    localparam logic [SUM_W-1:0] Y_SUM_RST = SUM_W'(WINDOW_LENGTH * int'(CENTRE_Y));

    // pipeline: a = input register, b = state updated, c = quotient, d = output

    // stage a
    logic               r_a_vld;
    logic [TAG_W-1:0]   r_a_tag;
    logic [COORD_W-1:0] r_a_x;
    logic [COORD_W-1:0] r_a_y;
    // stage b / c / d status
    logic               r_b_vld;
    t_status            r_b_status;
    logic               r_c_vld;
    t_status            r_c_status;
    logic               r_d_vld;
    t_status            r_d_status;
    // filter state
    logic [POS_W-1:0]   r_pos;
    logic [SUM_W-1:0]   r_x_sum;
    logic [SUM_W-1:0]   r_y_sum;
    logic [COORD_W-1:0] r_aim_x;
    logic [COORD_W-1:0] r_aim_y;

    logic               free_a, free_b, free_c, free_d;
    logic               move_a, move_b, move_c;
    logic               a_hit, a_centre;
    t_status            a_status;
    logic               upd;
    logic [POS_W-1:0]   n_pos;
    logic [SUM_W-1:0]   n_x_sum;
    logic [SUM_W-1:0]   n_y_sum;
    logic [COORD_W-1:0] old_x;
    logic [COORD_W-1:0] old_y;
    logic [COORD_W-1:0] quot_x;
    logic [COORD_W-1:0] quot_y;
    logic [COORD_W-1:0] n_aim_x;
    logic [COORD_W-1:0] n_aim_y;

    // a stage moves on when the next one is empty or moving itself
    assign free_d = !r_d_vld || i_m_axis_tready;
    assign move_c = r_c_vld && free_d;
    assign free_c = !r_c_vld || move_c;
    assign move_b = r_b_vld && free_c;
    assign free_b = !r_b_vld || move_b;
    assign move_a = r_a_vld && free_b;
    assign free_a = !r_a_vld || move_a;

    assign o_s_axis_tready = free_a;

    // classify the report in stage a; the centre marker wins over a window update
    assign a_hit    = (r_a_tag == ACCEPT_TAG);
    assign a_centre = a_hit && ((r_a_x == CENTRE_X) || (r_a_y == CENTRE_Y));

    always_comb begin
        priority if (!a_hit) begin
            a_status = STATUS_IGNORED;
        end else if (a_centre) begin
            a_status = STATUS_CENTRED;
        end else begin
            a_status = STATUS_FILTERED;
        end
    end

    assign upd = move_a && (a_status == STATUS_FILTERED);

    // write position advances only on a filtered update; the window prefetches
    // the entry at the next position so the oldest sample is ready in time
    assign n_pos = !upd ? r_pos : ((r_pos == POS_LAST) ? '0 : r_pos + 1'b1);

    cma_window #(
        .DEPTH       (WINDOW_LENGTH),
        .RESET_VALUE (CENTRE_X)
    ) u_win_x (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (upd),
        .i_wr_addr (r_pos),
        .i_wr_data (r_a_x),
        .i_rd_addr (n_pos),
        .o_rd_data (old_x)
    );

    cma_window #(
        .DEPTH       (WINDOW_LENGTH),
        .RESET_VALUE (CENTRE_Y)
    ) u_win_y (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (upd),
        .i_wr_addr (r_pos),
        .i_wr_data (r_a_y),
        .i_rd_addr (n_pos),
        .o_rd_data (old_y)
    );

    // running sums: drop the oldest sample, add the new one
    assign n_x_sum = r_x_sum - SUM_W'(old_x) + SUM_W'(r_a_x);
    assign n_y_sum = r_y_sum - SUM_W'(old_y) + SUM_W'(r_a_y);

    // the sum registers hold the value after the item in stage b, since an
    // item can only leave a when b is empty or empties at the same edge
    cma_div #(
        .WINDOW_LENGTH (WINDOW_LENGTH)
    ) u_div_x (
        .i_clk  (i_clk),
        .i_en   (move_b),
        .i_sum  (r_x_sum),
        .o_quot (quot_x)
    );

    cma_div #(
        .WINDOW_LENGTH (WINDOW_LENGTH)
    ) u_div_y (
        .i_clk  (i_clk),
        .i_en   (move_b),
        .i_sum  (r_y_sum),
        .o_quot (quot_y)
    );

    // held aim follows items in order as they enter the output register
    always_comb begin
        unique case (r_c_status)
            STATUS_FILTERED: begin
                n_aim_x = quot_x;
                n_aim_y = quot_y;
            end
            STATUS_CENTRED: begin
                n_aim_x = CENTRE_X;
                n_aim_y = CENTRE_Y;
            end
            default: begin
                n_aim_x = r_aim_x;
                n_aim_y = r_aim_y;
            end
        endcase
    end

    // control and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld    <= 1'b0;
            r_b_vld    <= 1'b0;
            r_c_vld    <= 1'b0;
            r_d_vld    <= 1'b0;
            r_b_status <= STATUS_IGNORED;
            r_c_status <= STATUS_IGNORED;
            r_d_status <= STATUS_IGNORED;
            r_pos      <= '0;
            r_x_sum    <= X_SUM_RST;
            r_y_sum    <= Y_SUM_RST;
            r_aim_x    <= CENTRE_X;
            r_aim_y    <= CENTRE_Y;
        end else begin
            if (free_a) begin
                r_a_vld <= i_s_axis_tvalid;
            end
            if (free_b) begin
                r_b_vld <= move_a;
            end
            if (move_a) begin
                r_b_status <= a_status;
            end
            if (free_c) begin
                r_c_vld <= move_b;
            end
            if (move_b) begin
                r_c_status <= r_b_status;
            end
            if (free_d) begin
                r_d_vld <= move_c;
            end
            if (move_c) begin
                r_d_status <= r_c_status;
                r_aim_x    <= n_aim_x;
                r_aim_y    <= n_aim_y;
            end
            r_pos <= n_pos;
            if (upd) begin
                r_x_sum <= n_x_sum;
                r_y_sum <= n_y_sum;
            end
        end
    end

    // input payload register
    always_ff @(posedge i_clk) begin
        if (free_a && i_s_axis_tvalid) begin
            r_a_tag <= i_s_axis_tuser;
            r_a_x   <= i_s_axis_tdata[15:0];
            r_a_y   <= i_s_axis_tdata[31:16];
        end
    end

    assign o_m_axis_tvalid = r_d_vld;
    assign o_m_axis_tdata  = {r_aim_y, r_aim_x};
    assign o_m_axis_tuser  = r_d_status;

endmodule

>>> sv/cma_checker.sv
`include "coordinate_moving_average_core_macros.svh"

module cma_checker
    import cma_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_s_axis_tvalid,
    input logic              o_s_axis_tready,
    input logic [31:0]       i_s_axis_tdata,
    input logic [TAG_W-1:0]  i_s_axis_tuser,
    input logic              o_m_axis_tvalid,
    input logic              i_m_axis_tready,
    input logic [31:0]       o_m_axis_tdata,
    input logic [1:0]        o_m_axis_tuser
);

    // a stalled result holds its transaction
    `CMA_ASSERT_NXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))

    // input backpressure only comes from a result waiting at the output
    `CMA_ASSERT_IMP(a_stall_source, !o_s_axis_tready, o_m_axis_tvalid && !i_m_axis_tready)

    // a centred result carries the centre coordinates
    `CMA_ASSERT_IMP(a_centre_aim, o_m_axis_tvalid && (o_m_axis_tuser == STATUS_CENTRED), (o_m_axis_tdata[15:0] == CENTRE_X) && (o_m_axis_tdata[31:16] == CENTRE_Y))

    // status is one of the three defined codes
    `CMA_ASSERT_IMP(a_status_code, o_m_axis_tvalid, (o_m_axis_tuser == STATUS_IGNORED) || (o_m_axis_tuser == STATUS_CENTRED) || (o_m_axis_tuser == STATUS_FILTERED))

endmodule

bind coordinate_moving_average_core cma_checker u_cma_checker (.*);
